### rtl/htnm_pkg.sv
package htnm_pkg;

  // frame geometry
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned IDX_W      = 10;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SLOPE_GAIN   = 2'd2;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // fixed point constants, unit length is 256*255
  localparam logic [15:0] UNIT_D       = 16'd65280;
  localparam logic [41:0] UNIT_D_SQ    = 42'd4261478400;
  localparam logic [41:0] SQ_BIT_INIT  = 42'd1 << 40;
  localparam logic [20:0] DIV_REM_INIT = 21'(UNIT_D / 2);
  localparam logic [4:0]  DIV_LAST     = 5'd16;
  localparam logic signed [47:0] BASE_Q = 48'sd128 * 48'sd65280 * 48'sd65536;
  localparam logic [23:0] NZ_BASE      = 24'd128 << 16;

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LOAD = 10'b0000000010,
    S_MUL1 = 10'b0000000100,
    S_MUL2 = 10'b0000001000,
    S_SUM  = 10'b0000010000,
    S_SQRT = 10'b0000100000,
    S_DIV  = 10'b0001000000,
    S_MULR = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

endpackage

### rtl/height_to_normal_map.sv
// Height map to normal map. Pixels come in raster order on the slave side
// (tuser 0) and the green byte is taken as height; each pixel of row r>0
// yields the normal of pixel (r-1, c), using forward differences that wrap
// at the right and bottom edges. After the last pixel of a frame, drain
// items (tuser 1) give the normals of the last row one at a time; pixels
// while draining and drains while filling are dropped. Writing the width or
// height restarts the frame. An item without a result leaves the sequencer
// idle; an item with a result holds s_tready low while it passes the 21-step
// square root and the 17-step reciprocal divider that share one sequencer;
// the next item is taken while that result still waits on the master side.
// The two row buffers are single-write memories that hold garbage until the
// first row of a frame has been written.
module height_to_normal_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel_word
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  // normal_x, normal_y, normal_z, pixel_row, pixel_column, 4 bits zero
  output logic [47:0] m_tdata,
  output logic        m_tlast,   // last_in_run
  output logic        m_tuser,   // frame_done
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int unsigned IW = htnm_pkg::IDX_W;
  localparam int unsigned DW = htnm_pkg::DIM_W;

  // configuration
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;
  logic [11:0]   gain;
  logic [DW-1:0] cfg_dim;

  // frame position
  logic          phase_drain;
  logic [IW-1:0] row;
  logic [IW-1:0] col;
  logic [IW-1:0] drain;

  htnm_pkg::state_t state;

  // row buffers
  logic [7:0]    prev_mem  [htnm_pkg::MAX_WIDTH];
  logic [7:0]    first_mem [htnm_pkg::MAX_WIDTH];
  logic [7:0]    prev_rd_a;
  logic [7:0]    prev_rd_b;
  logic [7:0]    first_rd;
  logic [IW-1:0] rd_addr_a;
  logic [IW-1:0] rd_addr_b;
  logic          prev_we;
  logic          first_we;

  // item in flight
  logic          is_drain;
  logic          use_held;
  logic          col_zero;
  logic [7:0]    down_hv;
  logic [7:0]    held_start;
  logic [IW-1:0] res_row;
  logic [IW-1:0] res_col;
  logic          res_done;

  // datapath
  logic signed [8:0]  dx;
  logic signed [8:0]  dy;
  logic signed [21:0] sx;
  logic signed [21:0] sy;
  logic signed [39:0] sx_w;
  logic signed [39:0] sy_w;
  logic [39:0]        sxx;
  logic [39:0]        syy;
  logic [41:0]        sq_x;
  logic [41:0]        sq_res;
  logic [41:0]        sq_bit;
  logic [41:0]        sq_trial;
  logic [20:0]        dv_rem;
  logic [21:0]        dv_shift;
  logic [16:0]        dv_q;
  logic [4:0]         dv_cnt;
  logic signed [39:0] px;
  logic signed [39:0] py;
  logic signed [47:0] tx;
  logic signed [47:0] ty;
  logic [23:0]        nz_sum;

  // handshake and position helpers
  logic          accept;
  logic          pix_ok;
  logic          drn_ok;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;
  logic [DW-1:0] drain_inc;
  logic          col_wrap;
  logic          row_wrap;
  logic          drain_wrap;
  logic [7:0]    hv;
  logic [7:0]    right_hv;
  logic [7:0]    down_sel;
  logic          out_free;
  logic [7:0]    nx;
  logic [7:0]    ny;

  assign s_tready   = (state == htnm_pkg::S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign pix_ok     = accept && (s_tuser == htnm_pkg::OP_PIXEL) && !phase_drain;
  assign drn_ok     = accept && (s_tuser == htnm_pkg::OP_DRAIN) && phase_drain;
  assign hv         = s_tdata[15:8];
  assign col_inc    = {1'b0, col} + DW'(1);
  assign row_inc    = {1'b0, row} + DW'(1);
  assign drain_inc  = {1'b0, drain} + DW'(1);
  assign col_wrap   = (col_inc >= w_eff);
  assign row_wrap   = (row_inc >= h_eff);
  assign drain_wrap = (drain_inc >= w_eff);
  assign out_free   = !m_tvalid || m_tready;

  // clamp of a written dimension to 1..max
  always_comb begin
    if (cfg_data[DW-1:0] == '0) begin
      cfg_dim = DW'(1);
    end else if (cfg_data[DW-1:0] > DW'(htnm_pkg::MAX_WIDTH)) begin
      cfg_dim = DW'(htnm_pkg::MAX_WIDTH);
    end else begin
      cfg_dim = cfg_data[DW-1:0];
    end
  end

  // buffer addresses and write enables
  always_comb begin
    if (s_tuser == htnm_pkg::OP_DRAIN) begin
      rd_addr_a = drain;
      rd_addr_b = drain_wrap ? '0 : drain_inc[IW-1:0];
    end else begin
      rd_addr_a = col;
      rd_addr_b = col_wrap ? '0 : col_inc[IW-1:0];
    end
    prev_we  = pix_ok;
    first_we = pix_ok && (row == '0);
  end

  // row buffers, read before write
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[col] <= hv;
    end
    if (first_we) begin
      first_mem[col] <= hv;
    end
    prev_rd_a <= prev_mem[rd_addr_a];
    prev_rd_b <= prev_mem[rd_addr_b];
    first_rd  <= first_mem[drain];
  end

  // neighbour selection once buffer data is back
  always_comb begin
    if (!use_held) begin
      right_hv = prev_rd_b;
    end else if (col_zero) begin
      right_hv = prev_rd_a;
    end else begin
      right_hv = held_start;
    end
    down_sel = is_drain ? first_rd : down_hv;
  end

  // square root trial and divider shift
  assign sq_trial = sq_res + sq_bit;
  assign dv_shift = {dv_rem, 1'b0};

  // scaled slopes widened to product width
  assign sx_w = {{18{sx[21]}}, sx};
  assign sy_w = {{18{sy[21]}}, sy};

  // final scaling, divide by 255*256*65536 via shift and one correction
  function automatic logic [7:0] to_byte(input logic signed [47:0] t);
    logic [15:0] y;
    logic [8:0]  rem;
    logic [7:0]  q0;
    begin
      y   = t[39:24];
      q0  = y[15:8];
      rem = {1'b0, y[7:0]} + {1'b0, q0};
      if (t[47]) begin
        to_byte = 8'd0;
      end else begin
        to_byte = q0 + ((rem >= 9'd255) ? 8'd1 : 8'd0);
      end
    end
  endfunction

  assign nx = to_byte(tx);
  assign ny = to_byte(ty);

  // configuration and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff       <= DW'(htnm_pkg::MAX_WIDTH);
      h_eff       <= DW'(htnm_pkg::MAX_HEIGHT);
      gain        <= 12'd256;
      phase_drain <= 1'b0;
      row         <= '0;
      col         <= '0;
      drain       <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          htnm_pkg::REG_FRAME_WIDTH: begin
            w_eff       <= cfg_dim;
            phase_drain <= 1'b0;
            row         <= '0;
            col         <= '0;
            drain       <= '0;
          end
          htnm_pkg::REG_FRAME_HEIGHT: begin
            h_eff       <= cfg_dim;
            phase_drain <= 1'b0;
            row         <= '0;
            col         <= '0;
            drain       <= '0;
          end
          htnm_pkg::REG_SLOPE_GAIN: begin
            gain <= cfg_data;
          end
          default: begin
          end
        endcase
      end else if (pix_ok) begin
        if (col_wrap) begin
          col <= '0;
          if (row_wrap) begin
            row         <= '0;
            phase_drain <= 1'b1;
            drain       <= '0;
          end else begin
            row <= row_inc[IW-1:0];
          end
        end else begin
          col <= col_inc[IW-1:0];
        end
      end else if (drn_ok) begin
        if (drain_wrap) begin
          phase_drain <= 1'b0;
          row         <= '0;
          col         <= '0;
          drain       <= '0;
        end else begin
          drain <= drain_inc[IW-1:0];
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htnm_pkg::S_IDLE;
      held_start <= 8'd0;
    end else begin
      unique case (state)
        htnm_pkg::S_IDLE: begin
          if ((pix_ok && (row != '0)) || drn_ok) begin
            state <= htnm_pkg::S_LOAD;
          end
        end
        htnm_pkg::S_LOAD: begin
          if (!is_drain && col_zero) begin
            held_start <= prev_rd_a;
          end
          state <= htnm_pkg::S_MUL1;
        end
        htnm_pkg::S_MUL1: state <= htnm_pkg::S_MUL2;
        htnm_pkg::S_MUL2: state <= htnm_pkg::S_SUM;
        htnm_pkg::S_SUM:  state <= htnm_pkg::S_SQRT;
        htnm_pkg::S_SQRT: begin
          if (sq_bit[0]) begin
            state <= htnm_pkg::S_DIV;
          end
        end
        htnm_pkg::S_DIV: begin
          if (dv_cnt == htnm_pkg::DIV_LAST) begin
            state <= htnm_pkg::S_MULR;
          end
        end
        htnm_pkg::S_MULR: state <= htnm_pkg::S_FIN;
        htnm_pkg::S_FIN:  state <= htnm_pkg::S_OUT;
        htnm_pkg::S_OUT: begin
          if (out_free) begin
            state <= htnm_pkg::S_IDLE;
          end
        end
        default: state <= htnm_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // item capture on transfer
    if (accept) begin
      is_drain <= (s_tuser == htnm_pkg::OP_DRAIN);
      down_hv  <= hv;
      if (s_tuser == htnm_pkg::OP_DRAIN) begin
        use_held <= 1'b0;
        col_zero <= 1'b0;
        res_row  <= h_eff[IW-1:0] - IW'(1);
        res_col  <= drain;
        res_done <= drain_wrap;
      end else begin
        use_held <= col_wrap;
        col_zero <= (col == '0);
        res_row  <= row - IW'(1);
        res_col  <= col;
        res_done <= 1'b0;
      end
    end
    // height differences
    if (state == htnm_pkg::S_LOAD) begin
      dx <= $signed({1'b0, prev_rd_a}) - $signed({1'b0, right_hv});
      dy <= $signed({1'b0, prev_rd_a}) - $signed({1'b0, down_sel});
    end
    // gain
    if (state == htnm_pkg::S_MUL1) begin
      sx <= dx * $signed({10'b0, gain});
      sy <= dy * $signed({10'b0, gain});
    end
    // squares
    if (state == htnm_pkg::S_MUL2) begin
      sxx <= $unsigned(sx_w * sx_w);
      syy <= $unsigned(sy_w * sy_w);
    end
    // squared length and root start
    if (state == htnm_pkg::S_SUM) begin
      sq_x   <= htnm_pkg::UNIT_D_SQ + {2'b0, sxx} + {2'b0, syy};
      sq_res <= '0;
      sq_bit <= htnm_pkg::SQ_BIT_INIT;
    end
    // one root digit per cycle
    if (state == htnm_pkg::S_SQRT) begin
      if (sq_x >= sq_trial) begin
        sq_x   <= sq_x - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
      dv_rem <= htnm_pkg::DIV_REM_INIT;
      dv_q   <= '0;
      dv_cnt <= '0;
    end
    // reciprocal length, one quotient bit per cycle
    if (state == htnm_pkg::S_DIV) begin
      if (dv_shift >= {1'b0, sq_res[20:0]}) begin
        dv_rem <= 21'(dv_shift - {1'b0, sq_res[20:0]});
        dv_q   <= {dv_q[15:0], 1'b1};
      end else begin
        dv_rem <= dv_shift[20:0];
        dv_q   <= {dv_q[15:0], 1'b0};
      end
      dv_cnt <= dv_cnt + 5'd1;
    end
    // components times reciprocal
    if (state == htnm_pkg::S_MULR) begin
      px <= sx_w * $signed({23'b0, dv_q});
      py <= sy_w * $signed({23'b0, dv_q});
    end
    // scale by 127 and offset by 128
    if (state == htnm_pkg::S_FIN) begin
      tx     <= htnm_pkg::BASE_Q + ((48'(py) <<< 7) - 48'(py));
      ty     <= htnm_pkg::BASE_Q - ((48'(px) <<< 7) - 48'(px));
      nz_sum <= htnm_pkg::NZ_BASE + ({7'b0, dv_q} << 7) - {7'b0, dv_q};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == htnm_pkg::S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == htnm_pkg::S_OUT) && out_free) begin
      m_tdata <= {4'b0, res_col, res_row, nz_sum[23:16], ny, nx};
      m_tlast <= 1'b1;
      m_tuser <= res_done;
    end
  end

`ifndef ASSERT_OFF
  // root of the squared length never falls below the unit length
  a_root_min: assert property (@(posedge clk) disable iff (rst)
    (state == htnm_pkg::S_SQRT) && sq_bit[0] |=> sq_res[20:0] >= 21'(htnm_pkg::UNIT_D))
    else $error("root below unit length");

  // reciprocal length stays within 1.0
  a_recip_max: assert property (@(posedge clk) disable iff (rst)
    (state == htnm_pkg::S_MULR) |-> dv_q <= 17'd65536)
    else $error("reciprocal above one");

  // scaled components are never negative
  a_comp_sign: assert property (@(posedge clk) disable iff (rst)
    (state == htnm_pkg::S_OUT) |-> !tx[47] && !ty[47])
    else $error("negative scaled component");
`endif

endmodule
